// ----- hdl/lmm_agc_pkg.sv -----
// Package for the linear min/max AGC: field widths, function codes and reset values.
// Depends on nothing; the interfaces and the top level import it.
package lmm_agc_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned NUM_W   = PIX_W + OUT_W;
  localparam int unsigned QCNT_W  = $clog2(OUT_W);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [OUT_W-1:0] scaled_t;

  // Function codes carried in the func field.
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  localparam pix_t    MIN_RESET  = 16'hFFFF;
  localparam pix_t    MAX_RESET  = 16'h0000;
  localparam scaled_t FULL_SCALE = 8'hFF;
  localparam scaled_t ZERO_SCALE = 8'h00;

endpackage

// ----- hdl/lmm_agc_if.sv -----
// Valid/ready channel interfaces for the linear min/max AGC input and result streams.
// Depends on lmm_agc_pkg.
interface lmm_agc_in_if;
  import lmm_agc_pkg::*;

  logic valid;
  logic ready;
  logic func;
  logic frame_start;
  pix_t pixel;

  modport source (output valid, output func, output frame_start, output pixel, input ready);
  modport sink   (input valid, input func, input frame_start, input pixel, output ready);
endinterface

interface lmm_agc_out_if;
  import lmm_agc_pkg::*;

  logic    valid;
  logic    ready;
  scaled_t scaled;

  modport source (output valid, output scaled, input ready);
  modport sink   (input valid, input scaled, output ready);
endinterface

// ----- hdl/linear_min_max_agc.sv -----
// Top level of the linear min/max AGC: 16-bit to 8-bit contrast stretch with a shared
// restoring divider. Depends on lmm_agc_pkg and the channel interfaces in lmm_agc_if.
//
//   Channel  | Direction | Payload                       | Notes
//   ---------+-----------+-------------------------------+------------------------------
//   in_ch    | sink      | func, frame_start, pixel[15:0]| measure or convert transaction
//   out_ch   | source    | scaled[7:0]                   | one per convert transaction
//
// A measure transaction is folded into the running minimum and maximum in the cycle it
// is accepted, so measures stream at one per cycle while no convert is in flight. A
// convert transaction goes from acceptance to the result register through the load
// state, which picks out the saturating cases and forms 255*(pixel-min), the divide
// state, in which a single subtract-and-compare unit produces one quotient bit per
// cycle, and the done state, which hands the quotient to the output register.
// Saturated results skip the divider. The input is not ready while a convert is in
// flight, so no new transaction is taken until its result has gone to the output
// register. The output register holds its transaction until out_ch.ready; a
// finished quotient waits in the done state until the register is free, so a stalled
// sink backs up into the input. Synchronous active-low reset sets the minimum to
// 65535, the maximum to 0 and empties the pipeline.
module linear_min_max_agc (
  input  logic clk,
  input  logic rst_n,
  lmm_agc_in_if.sink    in_ch,
  lmm_agc_out_if.source out_ch
);
  import lmm_agc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t  state_r, state_nxt;
  pix_t    min_r, min_nxt;
  pix_t    max_r, max_nxt;
  pix_t    pix_r, pix_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-2:0]   den_r, den_nxt;
  scaled_t quo_r, quo_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic    out_valid_r, out_valid_nxt;
  scaled_t scaled_r, scaled_nxt;

  logic    in_acc;
  pix_t    diff;
  pix_t    span;
  logic [NUM_W-1:0] den_ext;
  logic    take;
  pix_t    meas_min;
  pix_t    meas_max;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.scaled = scaled_r;

  assign diff    = pix_r - min_r;
  assign span    = max_r - min_r;
  assign den_ext = {1'b0, den_r};
  // The shared unit: one trial subtraction of the shifted divisor per cycle.
  assign take    = (rem_r >= den_ext);

  // A frame start restarts the extremes before the pixel is included.
  assign meas_min = in_ch.frame_start ? MIN_RESET : min_r;
  assign meas_max = in_ch.frame_start ? MAX_RESET : max_r;

  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    pix_nxt       = pix_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    scaled_nxt    = scaled_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_MEASURE) begin
            min_nxt = (in_ch.pixel <= meas_min) ? in_ch.pixel : meas_min;
            max_nxt = (in_ch.pixel >= meas_max) ? in_ch.pixel : meas_max;
          end else begin
            pix_nxt   = in_ch.pixel;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // An empty or flat range and pixels at or below the minimum give zero;
        // pixels at or above the maximum give full scale.
        if (max_r <= min_r || pix_r <= min_r) begin
          quo_nxt   = ZERO_SCALE;
          state_nxt = ST_DONE;
        end else if (pix_r >= max_r) begin
          quo_nxt   = FULL_SCALE;
          state_nxt = ST_DONE;
        end else begin
          // 255*x formed as x*256 - x.
          rem_nxt   = {diff, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, diff};
          den_nxt   = {span, {(OUT_W-1){1'b0}}};
          quo_nxt   = ZERO_SCALE;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (take) begin
          rem_nxt = rem_r - den_ext;
        end
        quo_nxt = {quo_r[OUT_W-2:0], take};
        den_nxt = den_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == QCNT_W'(OUT_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          scaled_nxt    = quo_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pix_r    <= pix_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    scaled_r <= scaled_nxt;
  end

endmodule

// ----- tb/sv/linear_min_max_agc_tb.sv -----
// Self-checking testbench for linear_min_max_agc: directed and random measure/convert traffic.
// Depends on lmm_agc_pkg, the channel interfaces in lmm_agc_if and the linear_min_max_agc top.
`timescale 1ns / 1ps

module linear_min_max_agc_tb;
  import lmm_agc_pkg::*;

  // Each side idles in about this many cycles out of a hundred.
  localparam int unsigned IDLE_PCT       = 21;
  // Random traffic stops once this many transactions have been accepted in total.
  localparam int unsigned TOTAL_ITEMS    = 1900;
  // Length of each long receiver hold-off, in cycles.
  localparam int unsigned LONG_HOLD      = 400;
  // Wait after the last expected result, so that any unexpected extra result shows up.
  localparam int unsigned DRAIN_CYCLES   = 40;
  // Longest quiet stretch of a correct run is one long hold-off plus a convert.
  localparam int unsigned WATCHDOG_LIMIT = 5 * LONG_HOLD;
  // Only the first mismatches are printed; all of them are counted.
  localparam int unsigned PRINT_LIMIT    = 40;

  // One expected stretched pixel together with what produced it, for the report line.
  typedef struct {
    scaled_t scaled;
    pix_t    pixel;
    pix_t    lo;
    pix_t    hi;
  } stretch_exp_t;

  // The scoreboard keeps its own running minimum and maximum. A measure transaction
  // folds into them; a convert transaction turns into one expected scaled value that
  // waits in order for the block's result.
  class stretch_scoreboard;
    pix_t         run_min;
    pix_t         run_max;
    stretch_exp_t pending_q[$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      run_min    = MIN_RESET;
      run_max    = MAX_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Linear stretch with saturation at both ends. An empty or flat range gives zero.
    function scaled_t stretch(pix_t p);
      int unsigned num;
      int unsigned den;
      if (run_max <= run_min) return ZERO_SCALE;
      if (p <= run_min) return ZERO_SCALE;
      if (p >= run_max) return FULL_SCALE;
      num = 255 * (int'(p) - int'(run_min));
      den = int'(run_max) - int'(run_min);
      return scaled_t'(num / den);
    endfunction

    function void note_input(logic func, logic frame_start, pix_t p);
      stretch_exp_t e;
      if (func == FUNC_MEASURE) begin
        if (frame_start) begin
          run_min = MIN_RESET;
          run_max = MAX_RESET;
        end
        if (p <= run_min) run_min = p;
        if (p >= run_max) run_max = p;
      end else begin
        // The frame_start flag has no effect on a convert.
        e.scaled = stretch(p);
        e.pixel  = p;
        e.lo     = run_min;
        e.hi     = run_max;
        pending_q.push_back(e);
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(scaled_t got);
      stretch_exp_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("scaled %0d arrived with no convert outstanding", got));
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got !== e.scaled)
        report_mismatch($sformatf("scaled got %0d, expected %0d (pixel %0d, min %0d, max %0d)",
                                  got, e.scaled, e.pixel, e.lo, e.hi));
    endtask
  endclass

  logic clk;
  logic rst_n;

  lmm_agc_in_if  in_ch ();
  lmm_agc_out_if out_ch ();

  linear_min_max_agc uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stretch_scoreboard sb = new();

  int unsigned n_sent;
  int unsigned n_measure;
  int unsigned n_convert;
  int unsigned n_frames;
  int unsigned n_noise;
  int unsigned long_holds;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Drive one transaction onto the input channel and wait until it is accepted.
  // Valid is left high afterwards, so the next call either keeps it high or drops it
  // for a random idle gap. Between transactions 600 and 1000 the sender never idles.
  task send_item(input logic func, input logic frame_start, input pix_t p);
    while (!(n_sent >= 600 && n_sent < 1000) && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= func;
    in_ch.frame_start <= frame_start;
    in_ch.pixel       <= p;
    // Signals read right at the edge still hold their pre-edge values, which is
    // exactly what the block sees when it decides to take the transaction.
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(func, frame_start, p);
    n_sent++;
    if (func == FUNC_MEASURE) n_measure++;
    else n_convert++;
  endtask

  function automatic pix_t clamp_pix(int v);
    if (v < 0) return MAX_RESET;
    if (v > 65535) return MIN_RESET;
    return pix_t'(v);
  endfunction

  // Pick a convert pixel relative to the measured window [lo, hi]: most often inside it,
  // often right at or next to its edges, and sometimes anywhere at all.
  function automatic pix_t pick_convert_pixel(int lo, int hi);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return clamp_pix($urandom_range(hi, lo));
    if (sel < 55) return clamp_pix($urandom_range(0, 1) ? lo : hi);
    if (sel < 75) return clamp_pix(($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 6) - 3);
    return pix_t'($urandom);
  endfunction

  // One well-formed frame: a measure with frame_start, further measures, then converts.
  // The window width varies from flat to the full 16-bit range.
  task send_frame();
    int          lo;
    int          hi;
    int          span;
    int unsigned shape;
    int unsigned n_meas;
    int unsigned n_conv;
    shape = $urandom_range(0, 9);
    case (shape)
      0:       span = 0;
      1, 2:    span = $urandom_range(1, 64);
      3, 4, 5: span = $urandom_range(65, 4096);
      6, 7:    span = $urandom_range(4097, 65535);
      default: span = 65535;
    endcase
    lo = $urandom_range(65535 - span, 0);
    hi = lo + span;
    n_meas = $urandom_range(1, 10);
    n_conv = $urandom_range(1, 10);
    n_frames++;
    // The first pixel opens the frame; the ends of the window are usually measured too.
    send_item(FUNC_MEASURE, 1'b1, clamp_pix($urandom_range(hi, lo)));
    if ($urandom_range(0, 3) != 0) send_item(FUNC_MEASURE, 1'b0, clamp_pix(lo));
    if ($urandom_range(0, 3) != 0) send_item(FUNC_MEASURE, 1'b0, clamp_pix(hi));
    repeat (n_meas) send_item(FUNC_MEASURE, 1'b0, clamp_pix($urandom_range(hi, lo)));
    repeat (n_conv) send_item(FUNC_CONVERT, 1'b0, pick_convert_pixel(lo, hi));
  endtask

  // Stimulus: reset, a directed pass over the special cases, then random frames
  // interleaved with stray transactions.
  initial begin : stimulus
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_MEASURE;
    in_ch.frame_start <= 1'b0;
    in_ch.pixel       <= '0;
    n_sent     = 0;
    n_measure  = 0;
    n_convert  = 0;
    n_frames   = 0;
    n_noise    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Converts before any measure: the empty range must give zero.
    send_item(FUNC_CONVERT, 1'b0, 16'h0000);
    send_item(FUNC_CONVERT, 1'b0, 16'hFFFF);
    send_item(FUNC_CONVERT, 1'b1, 16'h1234);
    // A single measured value leaves a flat range, which also gives zero.
    send_item(FUNC_MEASURE, 1'b1, 16'h8000);
    send_item(FUNC_CONVERT, 1'b0, 16'h8000);
    send_item(FUNC_CONVERT, 1'b0, 16'h0000);
    send_item(FUNC_CONVERT, 1'b0, 16'hFFFF);
    // Full 16-bit range.
    send_item(FUNC_MEASURE, 1'b0, 16'h0000);
    send_item(FUNC_MEASURE, 1'b0, 16'hFFFF);
    send_item(FUNC_CONVERT, 1'b0, 16'h0000);
    send_item(FUNC_CONVERT, 1'b0, 16'hFFFF);
    send_item(FUNC_CONVERT, 1'b0, 16'h7FFF);
    send_item(FUNC_CONVERT, 1'b0, 16'h0001);
    send_item(FUNC_CONVERT, 1'b0, 16'hFFFE);
    // A frame_start on a convert must leave the window alone.
    send_item(FUNC_CONVERT, 1'b1, 16'h4000);
    send_item(FUNC_CONVERT, 1'b0, 16'h8000);
    // Narrow window: saturation below and above, both edges and the interior.
    send_item(FUNC_MEASURE, 1'b1, 16'd100);
    send_item(FUNC_MEASURE, 1'b0, 16'd200);
    send_item(FUNC_CONVERT, 1'b0, 16'd50);
    send_item(FUNC_CONVERT, 1'b0, 16'd100);
    send_item(FUNC_CONVERT, 1'b0, 16'd150);
    send_item(FUNC_CONVERT, 1'b0, 16'd199);
    send_item(FUNC_CONVERT, 1'b0, 16'd200);
    send_item(FUNC_CONVERT, 1'b0, 16'd300);

    // Random part: mostly whole frames, with some stray transactions of any kind
    // that cut into frames or extend the window unannounced.
    while (n_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        n_noise++;
        send_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)), pix_t'($urandom));
      end else begin
        send_frame();
      end
    end
    in_ch.valid <= 1'b0;

    // Wait for every outstanding convert, then a few more cycles so that any
    // unexpected extra result has time to show up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("converts still outstanding at the end");

    $display("Covered %0d measure and %0d convert transactions in %0d frames plus %0d strays,",
             n_measure, n_convert, n_frames, n_noise);
    $display("checked %0d results, with %0d long output stalls; %0d mismatches.",
             sb.checked, long_holds, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result sink. It checks every accepted result and idles at random, except for a
  // stretch of steady acceptance. Twice it holds ready low for a long while, counted
  // here, so the result register and the finished quotient back up into the input
  // while the sender keeps offering transactions.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned results_seen;
    hold_left    = 0;
    results_seen = 0;
    long_holds   = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.scaled);
        results_seen++;
        if (results_seen == 150 || results_seen == 600) begin
          hold_left = LONG_HOLD;
          long_holds++;
        end
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= 300 && results_seen < 500) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count of quiet cycles.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d converts outstanding",
                 quiet, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
